### rtl/aar_pkg.sv
// Shared types, constants and tables for the axis-angle rotation matrix pipeline.
package aar_pkg;

	localparam int NUM_STAGES     = 22;
	localparam int FRAC_BITS      = 14;
	localparam int OUT_SH         = 30 - FRAC_BITS;

	localparam int PH_DIV         = 45;
	localparam int PH_RECIP_A     = 1456;
	localparam int PH_RECIP_B     = 47721858;
	localparam int PH_REM_SCALE   = 8192;

	localparam int CORD_STEPS     = 28;
	localparam int CORD_PER_STAGE = 4;
	localparam int CORD_STAGES    = CORD_STEPS / CORD_PER_STAGE;
	localparam int ROOT_PER_STAGE = 4;
	localparam int ROOT_STAGES    = 32 / ROOT_PER_STAGE;
	localparam int DIV_PER_STAGE  = 4;
	localparam int DIV_STAGES     = 32 / DIV_PER_STAGE;

	localparam int ST_CORD = 5;
	localparam int ST_QUAD = ST_CORD + CORD_STAGES;
	localparam int ST_ROOT = 3;
	localparam int ST_DIV  = ST_ROOT + ROOT_STAGES;
	localparam int ST_UNIT = ST_DIV + DIV_STAGES;
	localparam int ST_MUL1 = ST_UNIT + 1;
	localparam int ST_MUL2 = ST_UNIT + 2;
	localparam int ST_OUT  = ST_UNIT + 3;

	localparam logic signed [32:0] Q_ONE      = 33'sd1073741824;
	localparam logic signed [32:0] CORD_START = 33'sd652032874;
	localparam logic signed [35:0] OUT_LIM    = 36'sd1 <<< FRAC_BITS;
	localparam logic signed [35:0] ROUND_HALF = (36'sd1 <<< OUT_SH) >>> 1;
	localparam logic [15:0]        ID_DIAG    = OUT_LIM[15:0];

	localparam logic signed [32:0] ARC_TBL [CORD_STEPS] = '{
		33'sh020000000, 33'sh012E4051E, 33'sh009FB385B, 33'sh0051111D4,
		33'sh0028B0D43, 33'sh00145D7E1, 33'sh000A2F61E, 33'sh000517C55,
		33'sh00028BE53, 33'sh000145F2F, 33'sh0000A2F98, 33'sh0000517CC,
		33'sh000028BE6, 33'sh0000145F3, 33'sh00000A2F9, 33'sh00000517C,
		33'sh0000028BE, 33'sh00000145F, 33'sh000000A2F, 33'sh000000517,
		33'sh00000028B, 33'sh000000145, 33'sh0000000A2, 33'sh000000051,
		33'sh000000028, 33'sh000000014, 33'sh00000000A, 33'sh000000005
	};

	typedef logic [12:0] rem_tbl_t [PH_DIV];

	function automatic rem_tbl_t build_rem_tbl();
		rem_tbl_t t;
		for (int i = 0; i < PH_DIV; i++) begin
			t[i] = 13'((i * PH_REM_SCALE) / PH_DIV);
		end
		return t;
	endfunction

	localparam rem_tbl_t REM_TBL = build_rem_tbl();

	typedef enum logic [1:0] {
		QUAD_0   = 2'd0,
		QUAD_90  = 2'd1,
		QUAD_180 = 2'd2,
		QUAD_270 = 2'd3
	} quad_t;

	typedef struct packed {
		logic signed [31:0] angle_deg;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
	} in_t;

	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m10;
		logic signed [15:0] m11;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
		logic               axis_zero;
	} out_t;

	typedef struct packed {
		logic signed [32:0] c;
		logic signed [32:0] s;
		logic signed [32:0] t;
	} cst_t;

	typedef struct packed {
		logic signed [31:0] ux;
		logic signed [31:0] uy;
		logic signed [31:0] uz;
		logic               zero;
	} uvec_t;

	// Q1.30 product rounding: floor((p + 2^29) / 2^30)
	function automatic logic signed [36:0] qround(input logic signed [66:0] p);
		logic signed [66:0] sum;
		sum = p + 67'sd536870912;
		return sum[66:30];
	endfunction

	function automatic logic [15:0] to_out(input logic signed [34:0] e);
		logic signed [35:0] sum;
		logic signed [35:0] v;
		sum = 36'(e) + ROUND_HALF;
		v = sum >>> OUT_SH;
		if (v > OUT_LIM) begin
			v = OUT_LIM;
		end else if (v < -OUT_LIM) begin
			v = -OUT_LIM;
		end
		return v[15:0];
	endfunction

endpackage

### rtl/axis_angle_rotation_matrix.sv
// Axis-angle to 3x3 rotation matrix, top level.
// One transfer per cycle sustained while out_ready is high; the pipeline stalls under back-pressure.
// The square root and the three dividers (8 stages each) set the depth; every stage
// holds independently, so bubbles collapse under back-pressure.
// Reset clears the stage valid bits only; the datapath registers are not reset.
module axis_angle_rotation_matrix import aar_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	logic [NUM_STAGES:1] vld_q;
	logic [NUM_STAGES:1] en;
	logic [31:0]         phase_s4;
	cst_t                cst_s12;
	cst_t                dly_s [ST_QUAD+1:ST_UNIT];
	uvec_t               u_s19;

	assign en[NUM_STAGES] = !vld_q[NUM_STAGES] || out_ready;
	for (genvar k = 1; k < NUM_STAGES; k++) begin : g_en
		assign en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vld_q & ~en) | ({vld_q[NUM_STAGES-1:1], in_valid} & en);
		end
	end

	assign in_ready  = en[1];
	assign out_valid = vld_q[NUM_STAGES];

	aar_phase u_phase (
		.clk       (clk),
		.en        (en),
		.angle_deg (in_data.angle_deg),
		.phase_s4  (phase_s4)
	);

	aar_cordic u_cordic (
		.clk      (clk),
		.en       (en),
		.phase_s4 (phase_s4),
		.cst_s12  (cst_s12)
	);

	// hold cos/sin alongside the normaliser
	for (genvar k = ST_QUAD + 1; k <= ST_UNIT; k++) begin : g_dly
		if (k == ST_QUAD + 1) begin : g_first
			always_ff @(posedge clk) begin
				if (en[k]) begin
					dly_s[k] <= cst_s12;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en[k]) begin
					dly_s[k] <= dly_s[k-1];
				end
			end
		end
	end

	aar_norm u_norm (
		.clk    (clk),
		.en     (en),
		.axis_x (in_data.axis_x),
		.axis_y (in_data.axis_y),
		.axis_z (in_data.axis_z),
		.u_s19  (u_s19)
	);

	aar_matrix u_matrix (
		.clk     (clk),
		.en      (en),
		.u_s19   (u_s19),
		.cst_s19 (dly_s[ST_UNIT]),
		.res_s22 (out_data)
	);

endmodule

### rtl/aar_phase.sv
// Angle reduction: Q16.16 degrees to a 32-bit fraction of a full turn.
module aar_phase import aar_pkg::*; (
	input  logic                  clk,
	input  logic [NUM_STAGES:1]   en,
	input  logic signed [31:0]    angle_deg,
	output logic [31:0]           phase_s4
);

	logic [12:0] au_c;
	logic [23:0] pm_c;
	logic [12:0] au_s1;
	logic [23:0] pm_s1;
	logic [18:0] lo_s1;

	logic [7:0]  q1_c;
	logic [12:0] d13_c;
	logic [6:0]  r7_c;
	logic [5:0]  r6_c;
	logic [5:0]  rm_c;
	logic [24:0] m_s2;

	logic [50:0] mk_s3;
	logic [24:0] m_s3;

	logic [19:0] q20_c;
	logic [19:0] qq_c;
	logic [24:0] d25_c;
	logic [6:0]  s7_c;
	logic [5:0]  s6_c;

	// offset the count of 8-degree units so the mod-45 step sees an unsigned value
	assign au_c = {~angle_deg[31], angle_deg[30:19]};
	assign pm_c = 24'(au_c) * 24'(PH_RECIP_A);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			au_s1 <= au_c;
			pm_s1 <= pm_c;
			lo_s1 <= angle_deg[18:0];
		end
	end

	always_comb begin
		q1_c  = pm_s1[23:16];
		d13_c = au_s1 - 13'(13'(q1_c) * 13'(PH_DIV));
		r7_c  = d13_c[6:0];
		if (r7_c >= 7'(PH_DIV)) begin
			r6_c = 6'(r7_c - 7'(PH_DIV));
		end else begin
			r6_c = r7_c[5:0];
		end
		if (r6_c == 6'd0) begin
			rm_c = 6'(PH_DIV - 1);
		end else begin
			rm_c = r6_c - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			m_s2 <= {rm_c, lo_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			mk_s3 <= 51'(m_s2) * 51'(PH_RECIP_B);
			m_s3  <= m_s2;
		end
	end

	always_comb begin
		q20_c = mk_s3[50:31];
		d25_c = m_s3 - 25'(25'(q20_c) * 25'(PH_DIV));
		s7_c  = d25_c[6:0];
		if (s7_c >= 7'(PH_DIV)) begin
			s6_c = 6'(s7_c - 7'(PH_DIV));
			qq_c = q20_c + 20'd1;
		end else begin
			s6_c = s7_c[5:0];
			qq_c = q20_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			phase_s4 <= {qq_c[18:0], REM_TBL[s6_c]};
		end
	end

endmodule

### rtl/aar_cordic.sv
// Pipelined rotation-mode CORDIC with quadrant fold-out to cos, sin and 1 - cos.
module aar_cordic import aar_pkg::*; (
	input  logic                clk,
	input  logic [NUM_STAGES:1] en,
	input  logic [31:0]         phase_s4,
	output cst_t                cst_s12
);

	logic signed [32:0] cx_s [CORD_STAGES];
	logic signed [32:0] cy_s [CORD_STAGES];
	logic signed [32:0] cz_s [CORD_STAGES];
	quad_t              cq_s [CORD_STAGES];

	for (genvar g = 0; g < CORD_STAGES; g++) begin : g_stage
		logic signed [32:0] x0, y0, z0;
		quad_t              q0;
		logic signed [32:0] xv, yv, zv, dx, dy;

		if (g == 0) begin : g_init
			assign x0 = CORD_START;
			assign y0 = '0;
			assign z0 = 33'(phase_s4[29:0]);
			assign q0 = quad_t'(phase_s4[31:30]);
		end else begin : g_chain
			assign x0 = cx_s[g-1];
			assign y0 = cy_s[g-1];
			assign z0 = cz_s[g-1];
			assign q0 = cq_s[g-1];
		end

		always_comb begin
			xv = x0;
			yv = y0;
			zv = z0;
			dx = '0;
			dy = '0;
			for (int j = 0; j < CORD_PER_STAGE; j++) begin
				dx = yv >>> (g * CORD_PER_STAGE + j);
				dy = xv >>> (g * CORD_PER_STAGE + j);
				if (!zv[32]) begin
					xv = xv - dx;
					yv = yv + dy;
					zv = zv - ARC_TBL[5'(g * CORD_PER_STAGE + j)];
				end else begin
					xv = xv + dx;
					yv = yv - dy;
					zv = zv + ARC_TBL[5'(g * CORD_PER_STAGE + j)];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[ST_CORD + g]) begin
				cx_s[g] <= xv;
				cy_s[g] <= yv;
				cz_s[g] <= zv;
				cq_s[g] <= q0;
			end
		end
	end

	logic signed [32:0] xl, yl, c_c, s_c;

	assign xl = cx_s[CORD_STAGES-1];
	assign yl = cy_s[CORD_STAGES-1];

	always_comb begin
		case (cq_s[CORD_STAGES-1])
			QUAD_0: begin
				c_c = xl;
				s_c = yl;
			end
			QUAD_90: begin
				c_c = -yl;
				s_c = xl;
			end
			QUAD_180: begin
				c_c = -xl;
				s_c = -yl;
			end
			default: begin
				c_c = yl;
				s_c = -xl;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[ST_QUAD]) begin
			cst_s12.c <= c_c;
			cst_s12.s <= s_c;
			cst_s12.t <= Q_ONE - c_c;
		end
	end

endmodule

### rtl/aar_norm.sv
// Axis normaliser: squared length, pipelined square root and three pipelined dividers.
module aar_norm import aar_pkg::*; (
	input  logic                clk,
	input  logic [NUM_STAGES:1] en,
	input  logic signed [15:0]  axis_x,
	input  logic signed [15:0]  axis_y,
	input  logic signed [15:0]  axis_z,
	output uvec_t               u_s19
);

	typedef struct packed {
		logic [35:0]      rem;
		logic [31:0]      root;
		logic [31:0]      len2;
		logic [2:0][15:0] mag;
		logic [2:0]       neg;
		logic             zero;
	} root_t;

	typedef struct packed {
		logic [2:0][31:0] rem;
		logic [2:0][31:0] quot;
		logic [31:0]      r;
		logic [2:0]       neg;
		logic             zero;
	} div_t;

	logic signed [31:0] px_c, py_c, pz_c;
	logic [30:0]        sq_s1 [3];
	logic [2:0][15:0]   mag_s1;
	logic [2:0]         neg_s1;
	logic [31:0]        len2_s2;
	logic [2:0][15:0]   mag_s2;
	logic [2:0]         neg_s2;
	logic               zero_s2;

	assign px_c = axis_x * axis_x;
	assign py_c = axis_y * axis_y;
	assign pz_c = axis_z * axis_z;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			sq_s1[0] <= px_c[30:0];
			sq_s1[1] <= py_c[30:0];
			sq_s1[2] <= pz_c[30:0];
			mag_s1[0] <= axis_x[15] ? 16'(-axis_x) : axis_x;
			mag_s1[1] <= axis_y[15] ? 16'(-axis_y) : axis_y;
			mag_s1[2] <= axis_z[15] ? 16'(-axis_z) : axis_z;
			neg_s1 <= {axis_z[15], axis_y[15], axis_x[15]};
		end
	end

	logic [31:0] sum_c;
	assign sum_c = 32'(sq_s1[0]) + 32'(sq_s1[1]) + 32'(sq_s1[2]);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			len2_s2 <= sum_c;
			zero_s2 <= (sum_c == 32'd0);
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
		end
	end

	// floor(sqrt(len2 * 2^32)), two radicand bits per step
	root_t rt_s [ROOT_STAGES];

	for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_root
		root_t       prev, nxt;
		logic [35:0] trial;
		logic [1:0]  pr;

		if (g == 0) begin : g_init
			always_comb begin
				prev      = '0;
				prev.len2 = len2_s2;
				prev.mag  = mag_s2;
				prev.neg  = neg_s2;
				prev.zero = zero_s2;
			end
		end else begin : g_chain
			assign prev = rt_s[g-1];
		end

		always_comb begin
			nxt   = prev;
			trial = '0;
			pr    = '0;
			for (int j = 0; j < ROOT_PER_STAGE; j++) begin
				if (31 - (g * ROOT_PER_STAGE + j) >= 16) begin
					pr = 2'(nxt.len2 >> (2 * (15 - (g * ROOT_PER_STAGE + j))));
				end else begin
					pr = 2'b00;
				end
				nxt.rem = {nxt.rem[33:0], pr};
				trial   = {2'b00, nxt.root, 2'b01};
				if (nxt.rem >= trial) begin
					nxt.rem  = nxt.rem - trial;
					nxt.root = {nxt.root[30:0], 1'b1};
				end else begin
					nxt.root = {nxt.root[30:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[ST_ROOT + g]) begin
				rt_s[g] <= nxt;
			end
		end
	end

	// quotient (|a| * 2^46 + r/2) / r, restoring, one bit per step
	div_t dv_s [DIV_STAGES];

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		div_t        prev, nxt;
		logic [32:0] rem2;
		logic        nb;
		logic        qb;

		if (g == 0) begin : g_init
			always_comb begin
				prev      = '0;
				prev.r    = rt_s[ROOT_STAGES-1].root;
				prev.neg  = rt_s[ROOT_STAGES-1].neg;
				prev.zero = rt_s[ROOT_STAGES-1].zero;
				for (int k = 0; k < 3; k++) begin
					prev.rem[k] = {2'b00, rt_s[ROOT_STAGES-1].mag[k], 14'd0};
				end
			end
		end else begin : g_chain
			assign prev = dv_s[g-1];
		end

		always_comb begin
			nxt  = prev;
			rem2 = '0;
			nb   = 1'b0;
			qb   = 1'b0;
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < DIV_PER_STAGE; j++) begin
					if (g * DIV_PER_STAGE + j == 0) begin
						nb = 1'b0;
					end else begin
						nb = 1'(nxt.r >> (32 - (g * DIV_PER_STAGE + j)));
					end
					rem2 = {nxt.rem[k], nb};
					qb   = 1'b0;
					if (rem2 >= {1'b0, nxt.r}) begin
						rem2 = rem2 - {1'b0, nxt.r};
						qb   = 1'b1;
					end
					nxt.rem[k]  = rem2[31:0];
					nxt.quot[k] = {nxt.quot[k][30:0], qb};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[ST_DIV + g]) begin
				dv_s[g] <= nxt;
			end
		end
	end

	logic [31:0]        qc [3];
	logic signed [31:0] uc [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			qc[k] = dv_s[DIV_STAGES-1].quot[k];
			if (qc[k] > 32'(Q_ONE)) begin
				qc[k] = 32'(Q_ONE);
			end
			uc[k] = dv_s[DIV_STAGES-1].neg[k] ? -signed'(qc[k]) : signed'(qc[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_UNIT]) begin
			u_s19.ux   <= uc[0];
			u_s19.uy   <= uc[1];
			u_s19.uz   <= uc[2];
			u_s19.zero <= dv_s[DIV_STAGES-1].zero;
		end
	end

endmodule

### rtl/aar_matrix.sv
// Rodrigues products and sums, output rounding and saturation, identity output for a zero axis.
module aar_matrix import aar_pkg::*; (
	input  logic                clk,
	input  logic [NUM_STAGES:1] en,
	input  uvec_t               u_s19,
	input  cst_t                cst_s19,
	output out_t                res_s22
);

	logic signed [31:0] ux, uy, uz;
	logic signed [32:0] cc, ss, tt;
	logic signed [66:0] pr1 [9];
	logic signed [36:0] rq1 [9];

	assign ux = u_s19.ux;
	assign uy = u_s19.uy;
	assign uz = u_s19.uz;
	assign cc = cst_s19.c;
	assign ss = cst_s19.s;
	assign tt = cst_s19.t;

	// pairs xx xy xz yy yz zz, then x*s y*s z*s
	always_comb begin
		pr1[0] = ux * ux;
		pr1[1] = ux * uy;
		pr1[2] = ux * uz;
		pr1[3] = uy * uy;
		pr1[4] = uy * uz;
		pr1[5] = uz * uz;
		pr1[6] = ux * ss;
		pr1[7] = uy * ss;
		pr1[8] = uz * ss;
		for (int i = 0; i < 9; i++) begin
			rq1[i] = qround(pr1[i]);
		end
	end

	logic signed [31:0] uu_s20 [6];
	logic signed [32:0] us_s20 [3];
	logic signed [32:0] c_s20, t_s20;
	logic               zero_s20;

	always_ff @(posedge clk) begin
		if (en[ST_MUL1]) begin
			for (int i = 0; i < 6; i++) begin
				uu_s20[i] <= rq1[i][31:0];
			end
			for (int i = 0; i < 3; i++) begin
				us_s20[i] <= rq1[6+i][32:0];
			end
			c_s20    <= cc;
			t_s20    <= tt;
			zero_s20 <= u_s19.zero;
		end
	end

	logic signed [66:0] pr2 [6];
	logic signed [36:0] rq2 [6];

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			pr2[i] = uu_s20[i] * t_s20;
			rq2[i] = qround(pr2[i]);
		end
	end

	logic signed [33:0] a_s21  [6];
	logic signed [32:0] us_s21 [3];
	logic signed [32:0] c_s21;
	logic               zero_s21;

	always_ff @(posedge clk) begin
		if (en[ST_MUL2]) begin
			for (int i = 0; i < 6; i++) begin
				a_s21[i] <= rq2[i][33:0];
			end
			us_s21   <= us_s20;
			c_s21    <= c_s20;
			zero_s21 <= zero_s20;
		end
	end

	logic signed [34:0] e [9];

	always_comb begin
		e[0] = 35'(a_s21[0]) + 35'(c_s21);
		e[1] = 35'(a_s21[1]) - 35'(us_s21[2]);
		e[2] = 35'(a_s21[2]) + 35'(us_s21[1]);
		e[3] = 35'(a_s21[1]) + 35'(us_s21[2]);
		e[4] = 35'(a_s21[3]) + 35'(c_s21);
		e[5] = 35'(a_s21[4]) - 35'(us_s21[0]);
		e[6] = 35'(a_s21[2]) - 35'(us_s21[1]);
		e[7] = 35'(a_s21[4]) + 35'(us_s21[0]);
		e[8] = 35'(a_s21[5]) + 35'(c_s21);
	end

	always_ff @(posedge clk) begin
		if (en[ST_OUT]) begin
			if (zero_s21) begin
				res_s22.m00 <= ID_DIAG;
				res_s22.m01 <= '0;
				res_s22.m02 <= '0;
				res_s22.m10 <= '0;
				res_s22.m11 <= ID_DIAG;
				res_s22.m12 <= '0;
				res_s22.m20 <= '0;
				res_s22.m21 <= '0;
				res_s22.m22 <= ID_DIAG;
			end else begin
				res_s22.m00 <= to_out(e[0]);
				res_s22.m01 <= to_out(e[1]);
				res_s22.m02 <= to_out(e[2]);
				res_s22.m10 <= to_out(e[3]);
				res_s22.m11 <= to_out(e[4]);
				res_s22.m12 <= to_out(e[5]);
				res_s22.m20 <= to_out(e[6]);
				res_s22.m21 <= to_out(e[7]);
				res_s22.m22 <= to_out(e[8]);
			end
			res_s22.axis_zero <= zero_s21;
		end
	end

endmodule

### tb/axis_angle_rotation_matrix_tb.sv
// Testbench for the axis-angle rotation matrix pipeline: directed table, random traffic, checks.
module axis_angle_rotation_matrix_tb import aar_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam longint QONE = 64'sd1073741824;
	localparam longint TURN = 64'sd23592960;
	localparam int     FB   = 14;

	typedef struct {
		in_t  stim;
		bit   known;
		out_t res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_ready = 1'b0;
	in_t  in_data = '0;
	logic in_ready;
	logic out_valid;
	out_t out_data;

	out_t    matrix_q[$];
	int      n_bad = 0;
	bit      quiet_phase = 0;
	bit      hold_long = 0;
	longint  arcs[28] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
		64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
		64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
		64'h00000014, 64'h0000000A, 64'h00000005
	};

	axis_angle_rotation_matrix DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #2 clk = ~clk;

	function automatic longint fshr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint qm(longint a, longint b);
		return fshr(a * b + (64'sd1 <<< 29), 30);
	endfunction

	function automatic logic [15:0] to_q14(longint e);
		longint v;
		v = fshr(e + (64'sd1 <<< (29 - FB)), 30 - FB);
		if (v > (64'sd1 <<< FB))
			v = 64'sd1 <<< FB;
		if (v < -(64'sd1 <<< FB))
			v = -(64'sd1 <<< FB);
		return v[15:0];
	endfunction

	function automatic longint isqrt(logic [63:0] v);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint unit_comp(longint a, longint r);
		logic [63:0] mag, q;
		mag = a < 0 ? -a : a;
		q = ((mag << 46) + (r >> 1)) / r;
		if (q > QONE)
			q = QONE;
		return a < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic out_t rodrigues(in_t d);
		out_t o;
		longint ax, ay, az, l2, m, x, y, z, dx, dy, c, s, t, r, ux, uy, uz;
		logic [63:0] p;
		longint e[9];
		quad_t q;
		ax = d.axis_x;
		ay = d.axis_y;
		az = d.axis_z;
		l2 = ax * ax + ay * ay + az * az;
		if (l2 == 0) begin
			for (int i = 0; i < 9; i++)
				e[i] = (i % 4 == 0) ? QONE : 0;
		end else begin
			m = longint'(d.angle_deg) % TURN;
			if (m < 0)
				m += TURN;
			p = (unsigned'(m) << 32) / unsigned'(TURN);
			q = quad_t'(p[31:30]);
			z = p[29:0];
			x = 64'sd652032874;
			y = 0;
			for (int i = 0; i < 28; i++) begin
				dx = fshr(y, i);
				dy = fshr(x, i);
				if (z >= 0) begin
					x -= dx; y += dy; z -= arcs[i];
				end else begin
					x += dx; y -= dy; z += arcs[i];
				end
			end
			case (q)
				QUAD_0:   begin c = x;  s = y;  end
				QUAD_90:  begin c = -y; s = x;  end
				QUAD_180: begin c = -x; s = -y; end
				default:  begin c = y;  s = -x; end
			endcase
			t = QONE - c;
			r = isqrt(unsigned'(l2) << 32);
			ux = unit_comp(ax, r);
			uy = unit_comp(ay, r);
			uz = unit_comp(az, r);
			e[0] = qm(qm(ux, ux), t) + c;
			e[1] = qm(qm(ux, uy), t) - qm(uz, s);
			e[2] = qm(qm(ux, uz), t) + qm(uy, s);
			e[3] = qm(qm(uy, ux), t) + qm(uz, s);
			e[4] = qm(qm(uy, uy), t) + c;
			e[5] = qm(qm(uy, uz), t) - qm(ux, s);
			e[6] = qm(qm(uz, ux), t) - qm(uy, s);
			e[7] = qm(qm(uz, uy), t) + qm(ux, s);
			e[8] = qm(qm(uz, uz), t) + c;
		end
		o.m00 = to_q14(e[0]); o.m01 = to_q14(e[1]); o.m02 = to_q14(e[2]);
		o.m10 = to_q14(e[3]); o.m11 = to_q14(e[4]); o.m12 = to_q14(e[5]);
		o.m20 = to_q14(e[6]); o.m21 = to_q14(e[7]); o.m22 = to_q14(e[8]);
		o.axis_zero = (l2 == 0);
		return o;
	endfunction

	function automatic in_t rand_item();
		in_t d;
		int k;
		k = $urandom_range(0, 9);
		d.angle_deg = (k < 6) ? $signed($urandom_range(0, 2 * 23592960)) - 23592960 : $urandom;
		d.axis_x = $urandom;
		d.axis_y = $urandom;
		d.axis_z = $urandom;
		if (k == 7) begin
			d.axis_x = $signed(16'($urandom_range(0, 6))) - 3;
			d.axis_y = $signed(16'($urandom_range(0, 6))) - 3;
			d.axis_z = $signed(16'($urandom_range(0, 6))) - 3;
		end else if (k == 8) begin
			d.axis_y = 0;
			d.axis_z = 0;
		end else if (k == 9 && $urandom_range(0, 3) == 0) begin
			d.axis_x = 0; d.axis_y = 0; d.axis_z = 0;
		end
		return d;
	endfunction

	task automatic send(in_t d, bit known, out_t res);
		in_valid <= 1'b1;
		in_data <= d;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		matrix_q.push_back(known ? res : rodrigues(d));
	endtask

	task automatic idle_burst(bit en);
		if (en && !quiet_phase && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	// receiver side
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				out_ready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_long = 0;
			end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13) - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		out_t exp_m;
		if (arst_n && out_valid && out_ready) begin
			if (matrix_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("unexpected transfer: %p", out_data);
			end else begin
				exp_m = matrix_q.pop_front();
				if (exp_m !== out_data) begin
					n_bad++;
					if (n_bad <= 10)
						$display("mismatch: exp %p got %p", exp_m, out_data);
				end
			end
		end
	end

	initial begin
		#3000000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		dir_row_t rows[$];
		out_t ident;
		in_t d;
		int waited;
		ident = '0;
		ident.m00 = 16'sd16384; ident.m11 = 16'sd16384; ident.m22 = 16'sd16384;
		ident.axis_zero = 1'b1;
		rows.push_back('{'{32'sd0, 16'sd0, 16'sd0, 16'sd0}, 1, ident});
		rows.push_back('{'{32'h7FFFFFFF, 16'sd0, 16'sd0, 16'sd0}, 1, ident});
		rows.push_back('{'{32'h80000000, 16'sd0, 16'sd0, 16'sd0}, 1, ident});
		rows.push_back('{'{32'sd0, 16'sd256, 16'sd0, 16'sd0}, 0, ident});
		rows.push_back('{'{32'sd90 <<< 16, 16'sd0, 16'sd0, 16'sd256}, 0, ident});
		rows.push_back('{'{32'sd180 <<< 16, 16'sd0, 16'sd256, 16'sd0}, 0, ident});
		rows.push_back('{'{32'sd270 <<< 16, 16'sd256, 16'sd0, 16'sd0}, 0, ident});
		rows.push_back('{'{-(32'sd90 <<< 16), 16'sd0, 16'sd0, 16'sd256}, 0, ident});
		rows.push_back('{'{32'sd360 <<< 16, 16'sd1, 16'sd1, 16'sd1}, 0, ident});
		rows.push_back('{'{32'h7FFFFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 0, ident});
		rows.push_back('{'{32'h80000000, 16'h8000, 16'h8000, 16'h8000}, 0, ident});
		rows.push_back('{'{32'sd45 <<< 16, 16'h8000, 16'sd0, 16'h7FFF}, 0, ident});
		rows.push_back('{'{32'sd1, -16'sd1, 16'sd0, 16'sd0}, 0, ident});
		rows.push_back('{'{-32'sd1, 16'sd0, 16'h7FFF, -16'sd1}, 0, ident});
		rows.push_back('{'{32'sd30 <<< 16, 16'sd0, 16'sd0, 16'h8000}, 0, ident});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			send(rows[i].stim, rows[i].known, rows[i].res);
			idle_burst(1);
		end
		for (int n = 0; n < 1000; n++) begin
			if (n == 300)
				hold_long = 1;
			if (n == 850)
				quiet_phase = 1;
			d = rand_item();
			send(d, 0, ident);
			idle_burst(1);
		end
		in_valid <= 1'b0;
		waited = 0;
		while (matrix_q.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (n_bad == 0 && matrix_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
